FILE: sv/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared types and constants of the nearest free slot assigner
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int COORD_W  = 16;
  localparam int CAP_W    = 16;
  localparam int RID_W    = 16;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int SQ_W     = 32;
  localparam int DIST_W   = 33;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  localparam logic [APB_AW-1:0] ADDR_SITE_COUNT = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CAP_W-1:0]   left;
  } site_t;

  typedef struct packed {
    logic xy_en;
    logic left_en;
  } site_wr_t;

endpackage

FILE: sv/nfsa_site_mem.sv
// ----------------------------------------------------------------------------
// nfsa_site_mem
// site table: x, y and remaining capacity, one write and one registered read
// ----------------------------------------------------------------------------
module nfsa_site_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  nfsa_pkg::site_wr_t wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  nfsa_pkg::site_t   wr_data,
  input  logic [AW-1:0]     rd_addr,
  output nfsa_pkg::site_t   rd_data
);

  logic [nfsa_pkg::COORD_W-1:0] mem_x    [DEPTH];
  logic [nfsa_pkg::COORD_W-1:0] mem_y    [DEPTH];
  logic [nfsa_pkg::CAP_W-1:0]   mem_left [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.xy_en) begin
      mem_x[wr_addr] <= wr_data.x;
      mem_y[wr_addr] <= wr_data.y;
    end
    if (wr_en.left_en) begin
      mem_left[wr_addr] <= wr_data.left;
    end
    rd_data.x    <= mem_x[rd_addr];
    rd_data.y    <= mem_y[rd_addr];
    rd_data.left <= mem_left[rd_addr];
  end

endmodule

FILE: sv/nearest_free_slot_assigner_core.sv
// ----------------------------------------------------------------------------
// nearest_free_slot_assigner_core
// greedy nearest site assignment with per-site capacity
// ----------------------------------------------------------------------------
// A load beat (op 0) writes one site entry and the block stays ready for
// the next beat. An assign beat (op 1) scans sites 0 to site_count-1
// (capped at MAX_SITES) and returns one result beat; it holds the input
// stalled while it searches the sites and until the previous result beat,
// if still held by out_stall, has been taken. The scan uses the single
// shared 17x17 squarer, which squares dx and then dy of each site, with a
// new site table read only while phase is low and a read, difference,
// square and compare pipe.
// ----------------------------------------------------------------------------
module nearest_free_slot_assigner_core #(
  parameter int MAX_SITES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [nfsa_pkg::SLOT_W-1:0]   site_slot,
  input  logic [nfsa_pkg::RID_W-1:0]    requester_id,
  input  logic signed [nfsa_pkg::COORD_W-1:0] item_x,
  input  logic signed [nfsa_pkg::COORD_W-1:0] item_y,
  input  logic [nfsa_pkg::CAP_W-1:0]    item_capacity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nfsa_pkg::RID_W-1:0]    out_requester,
  output logic [nfsa_pkg::SLOT_W-1:0]   chosen_site,
  output logic                          assigned,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfsa_pkg::APB_AW-1:0]   paddr,
  input  logic [nfsa_pkg::APB_DW-1:0]   pwdata,
  output logic [nfsa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int NW = $clog2(MAX_SITES + 1);
  localparam int KW = (NW > nfsa_pkg::COUNT_W) ? NW : nfsa_pkg::COUNT_W;
  localparam int DW = nfsa_pkg::COORD_W + 1;

  nfsa_pkg::state_t state, state_next;

  logic [nfsa_pkg::COUNT_W-1:0] site_count;
  logic [NW-1:0]                n;
  logic [NW-1:0]                n_in;
  logic [NW-1:0]                ra;
  logic [NW-1:0]                cj;
  logic                         phase;
  logic [3:0]                   sh;

  logic [nfsa_pkg::RID_W-1:0]   rid;
  logic signed [nfsa_pkg::COORD_W-1:0] rx, ry;
  logic signed [DW-1:0]         dx, dy;
  logic [nfsa_pkg::CAP_W-1:0]   left_d, left2;
  logic [nfsa_pkg::SQ_W-1:0]    sqx, sqy;
  logic [nfsa_pkg::DIST_W-1:0]  best_d;
  logic [AW-1:0]                best_i;
  logic [nfsa_pkg::CAP_W-1:0]   best_left;
  logic                         found;

  logic                         acc;
  logic                         issue;
  logic                         cmp_last;
  logic                         fin_go;
  logic                         slot_ok;
  logic                         cfg_wr;

  logic signed [DW-1:0]         mop;
  logic signed [2*DW-1:0]       prod;
  logic [nfsa_pkg::SQ_W-1:0]    sq;
  logic [nfsa_pkg::DIST_W-1:0]  dsum;
  logic                         better;

  nfsa_pkg::site_wr_t           wr_en;
  logic [AW-1:0]                wr_addr;
  nfsa_pkg::site_t              wr_data;
  nfsa_pkg::site_t              rd_data;

  nfsa_site_mem #(
    .DEPTH (MAX_SITES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ra[AW-1:0]),
    .rd_data (rd_data)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == nfsa_pkg::ADDR_SITE_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr == nfsa_pkg::ADDR_SITE_COUNT) begin
      prdata = nfsa_pkg::APB_DW'(site_count);
    end
  end

  always_comb begin
    if (KW'(site_count) > KW'(MAX_SITES)) begin
      n_in = NW'(MAX_SITES);
    end else begin
      n_in = NW'(site_count);
    end
  end

  assign slot_ok = KW'(site_slot) < KW'(MAX_SITES);

  // shared squarer
  assign mop  = sh[1] ? dx : dy;
  assign prod = mop * mop;
  assign sq   = prod[nfsa_pkg::SQ_W-1:0];
  assign dsum = nfsa_pkg::DIST_W'(sqx) + nfsa_pkg::DIST_W'(sqy);
  assign better = (left2 != '0) && (!found || (dsum < best_d));

  // sequencer outputs
  always_comb begin
    in_stall = (state != nfsa_pkg::ST_IDLE);
    acc      = in_valid && (state == nfsa_pkg::ST_IDLE);
    issue    = (state == nfsa_pkg::ST_SCAN) && !phase && (ra < n);
    cmp_last = (state == nfsa_pkg::ST_SCAN) && sh[3] && (cj == NW'(n - 1'b1));
    fin_go   = (state == nfsa_pkg::ST_FINISH) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nfsa_pkg::ST_IDLE: begin
        if (acc && (op == nfsa_pkg::OP_ASSIGN)) begin
          state_next = (n_in == '0) ? nfsa_pkg::ST_FINISH : nfsa_pkg::ST_SCAN;
        end
      end
      nfsa_pkg::ST_SCAN: begin
        if (cmp_last) begin
          state_next = nfsa_pkg::ST_FINISH;
        end
      end
      nfsa_pkg::ST_FINISH: begin
        if (fin_go) begin
          state_next = nfsa_pkg::ST_IDLE;
        end
      end
      default: state_next = nfsa_pkg::ST_IDLE;
    endcase
  end

  // table write: loads when idle, capacity decrement at finish
  always_comb begin
    wr_en.xy_en   = acc && (op == nfsa_pkg::OP_LOAD) && slot_ok;
    wr_en.left_en = wr_en.xy_en || (fin_go && found);
    wr_data.x     = item_x;
    wr_data.y     = item_y;
    if (state == nfsa_pkg::ST_IDLE) begin
      wr_addr      = AW'(site_slot);
      wr_data.left = item_capacity;
    end else begin
      wr_addr      = best_i;
      wr_data.left = best_left - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nfsa_pkg::ST_IDLE;
      site_count <= '0;
      out_valid  <= 1'b0;
      sh         <= '0;
      phase      <= 1'b0;
      found      <= 1'b0;
      ra         <= '0;
      cj         <= '0;
      n          <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        site_count <= pwdata[nfsa_pkg::COUNT_W-1:0];
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (acc && (op == nfsa_pkg::OP_ASSIGN)) begin
        n     <= n_in;
        ra    <= '0;
        cj    <= '0;
        phase <= 1'b0;
        sh    <= '0;
        found <= 1'b0;
      end else if (state == nfsa_pkg::ST_SCAN) begin
        phase <= ~phase;
        sh    <= {sh[2:0], issue};
        if (issue) begin
          ra <= ra + 1'b1;
        end
        if (sh[3]) begin
          cj <= cj + 1'b1;
          if (better) begin
            found <= 1'b1;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (acc && (op == nfsa_pkg::OP_ASSIGN)) begin
      rid <= requester_id;
      rx  <= item_x;
      ry  <= item_y;
    end
    if (sh[0]) begin
      dx     <= {rd_data.x[nfsa_pkg::COORD_W-1], rd_data.x} - {rx[nfsa_pkg::COORD_W-1], rx};
      dy     <= {rd_data.y[nfsa_pkg::COORD_W-1], rd_data.y} - {ry[nfsa_pkg::COORD_W-1], ry};
      left_d <= rd_data.left;
    end
    if (sh[1]) begin
      sqx <= sq;
    end
    if (sh[2]) begin
      sqy   <= sq;
      left2 <= left_d;
    end
    if (sh[3] && better) begin
      best_d    <= dsum;
      best_i    <= cj[AW-1:0];
      best_left <= left2;
    end
    if (fin_go) begin
      out_requester <= rid;
      chosen_site   <= found ? nfsa_pkg::SLOT_W'(best_i) : '0;
      assigned      <= found;
    end
  end

endmodule

FILE: sv/nfsa_checker.sv
// ----------------------------------------------------------------------------
// nfsa_checker
// port-level checks of the nearest free slot assigner
// ----------------------------------------------------------------------------
module nfsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        op,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [nfsa_pkg::RID_W-1:0]  out_requester,
  input logic [nfsa_pkg::SLOT_W-1:0] chosen_site,
  input logic                        assigned
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_requester)
      && $stable(chosen_site) && $stable(assigned))
    else $error("result beat changed while stalled");

  // an assign beat occupies the block
  a_assign_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == nfsa_pkg::OP_ASSIGN) |=> in_stall)
    else $error("input not stalled after assign beat");

  // a load beat finishes at once
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == nfsa_pkg::OP_LOAD) |=> !in_stall)
    else $error("input stalled after load beat");

  // no free site reports site zero
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !assigned |-> chosen_site == '0)
    else $error("nonzero site without assignment");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat present after reset");

endmodule

bind nearest_free_slot_assigner_core nfsa_checker u_nfsa_checker (.*);

FILE: test/nearest_free_slot_assigner_core_tb.sv
// ----------------------------------------------------------------------------
// nearest_free_slot_assigner_core_tb
// self-checking bench for the nearest free slot assigner
// ----------------------------------------------------------------------------
// Loads site entries and sends assign requests over the valid/stall input,
// with the site count set through the APB port between phases. A short
// directed table covers coordinate extremes, empty and exhausted sites and
// ties, and random phases follow, some with counts above the table size.
// Every result beat is compared with a local site table model that picks
// the nearest site with capacity left. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module nearest_free_slot_assigner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SITES    = 64;
  localparam int DRAIN_CYCLES = 2 * NUM_SITES + 45;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BEATS = 900;
  localparam int PHASE_BEATS  = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic                            has_cnt;
    logic [nfsa_pkg::COUNT_W-1:0]    cnt;
    logic                            op;
    logic [nfsa_pkg::SLOT_W-1:0]     slot;
    logic [nfsa_pkg::RID_W-1:0]      rid;
    logic [nfsa_pkg::COORD_W-1:0]    x;
    logic [nfsa_pkg::COORD_W-1:0]    y;
    logic [nfsa_pkg::CAP_W-1:0]      cap;
    logic                            typed;
    logic [nfsa_pkg::SLOT_W-1:0]     exp_site;
    logic                            exp_granted;
  } beat_t;

  typedef struct packed {
    logic [nfsa_pkg::RID_W-1:0]  rid;
    logic [nfsa_pkg::SLOT_W-1:0] site;
    logic                        granted;
  } grant_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [nfsa_pkg::SLOT_W-1:0] site_slot;
  logic [nfsa_pkg::RID_W-1:0] requester_id;
  logic signed [nfsa_pkg::COORD_W-1:0] item_x;
  logic signed [nfsa_pkg::COORD_W-1:0] item_y;
  logic [nfsa_pkg::CAP_W-1:0] item_capacity;
  logic out_valid;
  logic out_stall;
  logic [nfsa_pkg::RID_W-1:0] out_requester;
  logic [nfsa_pkg::SLOT_W-1:0] chosen_site;
  logic assigned;
  logic psel;
  logic penable;
  logic pwrite;
  logic [nfsa_pkg::APB_AW-1:0] paddr;
  logic [nfsa_pkg::APB_DW-1:0] pwdata;
  logic [nfsa_pkg::APB_DW-1:0] prdata;
  logic pready;

  nearest_free_slot_assigner_core #(
    .MAX_SITES(NUM_SITES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .site_slot    (site_slot),
    .requester_id (requester_id),
    .item_x       (item_x),
    .item_y       (item_y),
    .item_capacity(item_capacity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_requester(out_requester),
    .chosen_site  (chosen_site),
    .assigned     (assigned),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // site table as seen by the bench
  logic signed [nfsa_pkg::COORD_W-1:0] tbl_x [NUM_SITES];
  logic signed [nfsa_pkg::COORD_W-1:0] tbl_y [NUM_SITES];
  logic [nfsa_pkg::CAP_W-1:0] tbl_left [NUM_SITES];
  logic [nfsa_pkg::COUNT_W-1:0] count_setting;

  grant_t grants_due[$];
  beat_t plan[$];

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned n_loads;
  int unsigned n_assigns;
  int unsigned n_granted;
  int unsigned n_refused;
  int unsigned n_settings;
  bit calm;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               grants_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic grant_t grant_nearest(
    input logic [nfsa_pkg::RID_W-1:0] rid,
    input logic signed [nfsa_pkg::COORD_W-1:0] rx,
    input logic signed [nfsa_pkg::COORD_W-1:0] ry
  );
    grant_t g;
    longint dx;
    longint dy;
    longint d;
    longint best;
    int n;
    g = '0;
    g.rid = rid;
    best = 0;
    n = (count_setting > NUM_SITES) ? NUM_SITES : int'(count_setting);
    for (int j = 0; j < n; j++) begin
      if (tbl_left[j] != '0) begin
        dx = longint'(tbl_x[j]) - longint'(rx);
        dy = longint'(tbl_y[j]) - longint'(ry);
        d = dx * dx + dy * dy;
        if (!g.granted || d < best) begin
          g.granted = 1'b1;
          g.site = nfsa_pkg::SLOT_W'(j);
          best = d;
        end
      end
    end
    if (g.granted) tbl_left[g.site] = tbl_left[g.site] - 1'b1;
    return g;
  endfunction

  always @(posedge clk) begin : check_results
    grant_t e;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (grants_due.size() == 0) begin
        report_mismatch("result beat with nothing pending, requester", out_requester, '0);
      end else begin
        e = grants_due.pop_front();
        if (out_requester !== e.rid) report_mismatch("out_requester", out_requester, e.rid);
        if (chosen_site !== e.site) report_mismatch("chosen_site", chosen_site, e.site);
        if (assigned !== e.granted) report_mismatch("assigned", assigned, e.granted);
      end
    end
  end

  // result side: random stall per beat, one long hold on request
  initial begin : result_side
    int unsigned w;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (long_hold) begin
        w = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        w = calm ? 0 : $urandom_range(0, 17);
      end
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  task automatic offer_beat(input beat_t b);
    int unsigned gap;
    grant_t g;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= b.op;
    site_slot     <= b.slot;
    requester_id  <= b.rid;
    item_x        <= b.x;
    item_y        <= b.y;
    item_capacity <= b.cap;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (b.op == nfsa_pkg::OP_LOAD) begin
      tbl_x[b.slot] = b.x;
      tbl_y[b.slot] = b.y;
      tbl_left[b.slot] = b.cap;
      n_loads++;
    end else begin
      g = grant_nearest(b.rid, b.x, b.y);
      if (b.typed) begin
        g.site = b.exp_site;
        g.granted = b.exp_granted;
      end
      grants_due = {grants_due, g};
      n_assigns++;
      if (g.granted) n_granted++;
      else n_refused++;
    end
  endtask

  task automatic settle(input bit with_drain);
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0);
    if (with_drain) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input beat_t b);
    plan = {plan, b};
  endtask

  task automatic write_site_count(input logic [nfsa_pkg::COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= nfsa_pkg::ADDR_SITE_COUNT;
    pwdata  <= nfsa_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    count_setting = value;
    n_settings++;
  endtask

  function automatic beat_t mk_load(input int slot, input int x, input int y, input int cap);
    beat_t b;
    b = '0;
    b.op = nfsa_pkg::OP_LOAD;
    b.slot = nfsa_pkg::SLOT_W'(slot);
    b.rid = nfsa_pkg::RID_W'($urandom);
    b.x = nfsa_pkg::COORD_W'(x);
    b.y = nfsa_pkg::COORD_W'(y);
    b.cap = nfsa_pkg::CAP_W'(cap);
    return b;
  endfunction

  function automatic beat_t mk_assign(input int rid, input int x, input int y);
    beat_t b;
    b = '0;
    b.op = nfsa_pkg::OP_ASSIGN;
    b.slot = nfsa_pkg::SLOT_W'($urandom);
    b.rid = nfsa_pkg::RID_W'(rid);
    b.x = nfsa_pkg::COORD_W'(x);
    b.y = nfsa_pkg::COORD_W'(y);
    b.cap = nfsa_pkg::CAP_W'($urandom);
    return b;
  endfunction

  function automatic beat_t with_grant(input beat_t b, input int site, input bit granted);
    b.typed = 1'b1;
    b.exp_site = nfsa_pkg::SLOT_W'(site);
    b.exp_granted = granted;
    return b;
  endfunction

  function automatic beat_t with_count(input beat_t b, input int cnt);
    b.has_cnt = 1'b1;
    b.cnt = nfsa_pkg::COUNT_W'(cnt);
    return b;
  endfunction

  function automatic logic [nfsa_pkg::COORD_W-1:0] pick_coord();
    int c;
    if ($urandom_range(0, 1) == 0) begin
      c = $urandom_range(0, 8);
      return nfsa_pkg::COORD_W'(c - 4);
    end
    return nfsa_pkg::COORD_W'($urandom);
  endfunction

  function automatic beat_t random_beat(input int load_pct);
    beat_t b;
    int r;
    b = '0;
    b.op = ($urandom_range(0, 99) < load_pct) ? nfsa_pkg::OP_LOAD : nfsa_pkg::OP_ASSIGN;
    b.slot = nfsa_pkg::SLOT_W'($urandom);
    b.rid = nfsa_pkg::RID_W'($urandom);
    b.x = pick_coord();
    b.y = pick_coord();
    r = $urandom_range(0, 19);
    if (r < 3) b.cap = '0;
    else if (r < 15) b.cap = nfsa_pkg::CAP_W'($urandom_range(1, 3));
    else b.cap = nfsa_pkg::CAP_W'($urandom);
    return b;
  endfunction

  initial begin : stimulus
    beat_t b;
    int sent;
    int phase;
    logic [nfsa_pkg::COUNT_W-1:0] cnt;
    logic [nfsa_pkg::COUNT_W-1:0] fixed_counts [5];

    fixed_counts = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd63};
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    op            <= nfsa_pkg::OP_LOAD;
    site_slot     <= '0;
    requester_id  <= '0;
    item_x        <= '0;
    item_y        <= '0;
    item_capacity <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (int i = 0; i < NUM_SITES; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_left[i] = '0;
    end
    count_setting = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no sites searched straight after reset
    add_row(with_grant(mk_assign(16'hffff, 32767, -32768), 0, 1'b0));
    add_row(mk_load(0, -32768, -32768, 1));
    add_row(mk_load(1, 32767, 32767, 16'hffff));
    add_row(mk_load(2, 0, 0, 0));
    add_row(mk_load(3, 0, 0, 2));
    add_row(mk_load(4, 5, 0, 1));
    add_row(mk_load(5, -5, 0, 1));
    add_row(mk_load(63, 1, -1, 1));
    add_row(with_count(with_grant(mk_assign(0, -32768, -32768), 0, 1'b1), 6));
    add_row(with_grant(mk_assign(1, 32767, 32767), 1, 1'b1));
    // zero capacity site 2 is skipped in favour of site 3
    add_row(with_grant(mk_assign(2, 0, 0), 3, 1'b1));
    add_row(with_grant(mk_assign(3, 0, 0), 3, 1'b1));
    // tie between sites 4 and 5
    add_row(mk_assign(4, 0, 0));
    add_row(mk_assign(5, 0, 0));
    // only the far corner site is left
    add_row(mk_assign(6, -32768, -32768));
    add_row(mk_load(2, 0, 0, 1));
    add_row(mk_assign(7, 1, 1));
    add_row(with_count(with_grant(mk_assign(8, 0, 0), 0, 1'b0), 1));
    foreach (plan[i]) begin
      if (plan[i].has_cnt) begin
        settle(1'b1);
        write_site_count(plan[i].cnt);
      end
      offer_beat(plan[i]);
    end

    // fill the whole table so any site count is legal
    for (int s = 0; s < NUM_SITES; s++) begin
      b = random_beat(100);
      b.slot = nfsa_pkg::SLOT_W'(s);
      offer_beat(b);
    end

    sent = NUM_SITES;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      settle(1'b1);
      if (phase < 5) cnt = fixed_counts[phase];
      else if ($urandom_range(0, 9) == 0) cnt = nfsa_pkg::COUNT_W'($urandom_range(0, 127));
      else cnt = nfsa_pkg::COUNT_W'($urandom_range(1, 10));
      write_site_count(cnt);
      calm = (phase % 4 == 3);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (phase == 5 && i == 5) long_hold = 1'b1;
        if (phase == 6 && i == 30) settle(1'b0);
        offer_beat(random_beat(30));
        sent++;
      end
      phase++;
    end
    calm = 1'b0;

    settle(1'b1);
    $display("sent %0d loads and %0d assigns over %0d site count settings",
             n_loads, n_assigns, n_settings);
    $display("%0d requests placed, %0d found no free site", n_granted, n_refused);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: nearest_free_slot_assigner_core.f
sv/nfsa_pkg.sv
sv/nfsa_site_mem.sv
sv/nearest_free_slot_assigner_core.sv
sv/nfsa_checker.sv
test/nearest_free_slot_assigner_core_tb.sv
